// ===== src/hlwr_pkg.sv =====
package hlwr_pkg;

    // Field and accumulator widths.
    localparam int IN_W     = 16;
    localparam int LOSS_W   = 48;
    localparam int WSUM_W   = 40;
    localparam int PROD_W   = 32;
    localparam int HINGE_W  = 17;
    localparam int MODE_W   = 2;

    // Parameter defaults.
    localparam int MAX_ELEMENTS_DEF = 65536;
    localparam int FRAC_BITS_DEF    = 8;

    // Reduction modes.
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUM   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MEAN  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd3;

    // Saturation limits of the loss and weight-sum accumulators and the result.
    localparam logic [LOSS_W-1:0] LOSS_MAX = {1'b0, {(LOSS_W-1){1'b1}}};
    localparam logic [LOSS_W-1:0] LOSS_MIN = {1'b1, {(LOSS_W-1){1'b0}}};
    localparam logic [WSUM_W-1:0] WSUM_MAX = {1'b0, {(WSUM_W-1){1'b1}}};
    localparam logic [WSUM_W-1:0] WSUM_MIN = {1'b1, {(WSUM_W-1){1'b0}}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic s1_load;
        logic advance;
        logic div_load;
        logic div_step;
        logic fin_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emits;
        logic needs_div;
    } sts_t;

endpackage

// ===== src/hlwr_ctrl.sv =====
module hlwr_ctrl #(
    parameter int FRAC_BITS = hlwr_pkg::FRAC_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  hlwr_pkg::sts_t  sts,
    output hlwr_pkg::cmd_t  cmd
);

    localparam int DVW   = hlwr_pkg::LOSS_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVW + 1);

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             advance;
    logic             accept;
    logic             fin_load;

    // The output register can take a new beat when empty or being drained.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = (state_reg == ST_RUN) && s1_valid_reg && out_free;
    assign s_ready  = (state_reg == ST_RUN) && (!s1_valid_reg || advance);
    assign accept   = s_valid && s_ready;
    assign fin_load = (state_reg == ST_FIN) && out_free;
    assign m_valid  = out_valid_reg;

    assign cmd.s1_load  = accept;
    assign cmd.advance  = advance;
    assign cmd.div_load = (state_reg == ST_LOAD);
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.fin_load = fin_load;

    // Next-state logic for the sequencer and the valid flags.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;

        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end

        if ((advance && sts.emits) || fin_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_RUN: begin
                if (advance && sts.needs_div) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_DIV;
                cnt_next   = CNT_W'(DVW);
            end
            ST_DIV: begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_load) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/hlwr_dp.sv =====
module hlwr_dp #(
    parameter int MAX_ELEMENTS = hlwr_pkg::MAX_ELEMENTS_DEF,
    parameter int FRAC_BITS    = hlwr_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [hlwr_pkg::MODE_W-1:0]        cfg_wr_data,
    input  logic signed [hlwr_pkg::IN_W-1:0]   s_logit,
    input  logic                               s_label_bit,
    input  logic signed [hlwr_pkg::IN_W-1:0]   s_weight,
    input  logic                               s_last_element,
    output logic signed [hlwr_pkg::LOSS_W-1:0] m_result_value,
    output logic                               m_is_last,
    input  hlwr_pkg::cmd_t                     cmd,
    output hlwr_pkg::sts_t                     sts
);

    localparam int IW    = hlwr_pkg::IN_W;
    localparam int LW    = hlwr_pkg::LOSS_W;
    localparam int WW    = hlwr_pkg::WSUM_W;
    localparam int PW    = hlwr_pkg::PROD_W;
    localparam int HW    = hlwr_pkg::HINGE_W;
    localparam int DVW   = LW + FRAC_BITS;
    localparam int DSW   = WW;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [HW-1:0] ONE = HW'(1 << FRAC_BITS);

    logic [hlwr_pkg::MODE_W-1:0] mode_reg;

    // Input stage signals.
    logic signed [HW-1:0]   logit_x;
    logic signed [HW-1:0]   y_logit;
    logic signed [HW-1:0]   hinge;
    logic [HW-2:0]          hinge_pos;
    logic signed [PW:0]     prod;
    logic signed [PW-1:0]   loss_reg;
    logic signed [IW-1:0]   w_reg;
    logic                   last_reg;

    // Accumulators.
    logic signed [LW-1:0]   lsum_reg, lsum_next;
    logic signed [WW-1:0]   wsum_reg, wsum_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [LW:0]     lsum_ext;
    logic signed [WW:0]     wsum_ext;
    logic [LW-1:0]          lsum_sat;
    logic [WW-1:0]          wsum_sat;
    logic [CNT_W-1:0]       cnt_inc;

    // Divider.
    logic                   mean_sel;
    logic [DVW-1:0]         dvd;
    logic [DVW-1:0]         dvd_mag;
    logic [DSW-1:0]         dsr;
    logic [DVW-1:0]         quo_reg;
    logic [DSW-1:0]         rem_reg;
    logic [DSW-1:0]         dsr_reg;
    logic                   neg_reg;
    logic                   zero_reg;
    logic [DSW:0]           rem_sh;
    logic [DSW+1:0]         diff;
    logic                   take;
    logic [LW-1:0]          quo_sat;
    logic                   quo_ovf;

    // Mode register; the user must write it only while the block is idle, which the block itself does not enforce.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= hlwr_pkg::MODE_NONE;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    // Hinge term max(0, 1 - y*logit) times the weight, computed at intake.
    assign logit_x   = HW'(s_logit);
    assign y_logit   = s_label_bit ? logit_x : -logit_x;
    assign hinge     = $signed(ONE) - y_logit;
    assign hinge_pos = hinge[HW-1] ? '0 : hinge[HW-2:0];
    assign prod      = $signed({1'b0, hinge_pos}) * s_weight;

    always_ff @(posedge aclk) begin
        if (cmd.s1_load) begin
            loss_reg <= prod[PW-1:0];
            w_reg    <= s_weight;
            last_reg <= s_last_element;
        end
    end

    // Status for the controller. Only per-element losses and the plain sum
    // leave straight from the input stage; the divided modes leave through
    // the divider.
    assign sts.emits     = (mode_reg == hlwr_pkg::MODE_NONE) ||
                           (last_reg && (mode_reg == hlwr_pkg::MODE_SUM));
    assign sts.needs_div = last_reg && ((mode_reg == hlwr_pkg::MODE_MEAN) ||
                                        (mode_reg == hlwr_pkg::MODE_COUNT));

    // Saturating accumulation of the loss, the weight and the nonzero count.
    assign lsum_ext = (LW+1)'(lsum_reg) + (LW+1)'(loss_reg);
    assign wsum_ext = (WW+1)'(wsum_reg) + (WW+1)'(w_reg);

    always_comb begin
        if (lsum_ext[LW] != lsum_ext[LW-1]) begin
            lsum_sat = lsum_ext[LW] ? hlwr_pkg::LOSS_MIN : hlwr_pkg::LOSS_MAX;
        end else begin
            lsum_sat = lsum_ext[LW-1:0];
        end
        if (wsum_ext[WW] != wsum_ext[WW-1]) begin
            wsum_sat = wsum_ext[WW] ? hlwr_pkg::WSUM_MIN : hlwr_pkg::WSUM_MAX;
        end else begin
            wsum_sat = wsum_ext[WW-1:0];
        end
        if ((w_reg != '0) && (cnt_reg < CNT_W'(MAX_ELEMENTS))) begin
            cnt_inc = cnt_reg + CNT_W'(1);
        end else begin
            cnt_inc = cnt_reg;
        end
    end

    // Accumulators clear after the last element; before a division they
    // hold the totals until the divider has taken its operands.
    always_comb begin
        lsum_next = lsum_reg;
        wsum_next = wsum_reg;
        cnt_next  = cnt_reg;
        if (cmd.advance) begin
            if (last_reg && !sts.needs_div) begin
                lsum_next = '0;
                wsum_next = '0;
                cnt_next  = '0;
            end else begin
                lsum_next = lsum_sat;
                wsum_next = wsum_sat;
                cnt_next  = cnt_inc;
            end
        end else if (cmd.div_load) begin
            lsum_next = '0;
            wsum_next = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lsum_reg <= '0;
            wsum_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            lsum_reg <= lsum_next;
            wsum_reg <= wsum_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Divider operands as magnitudes, with the quotient sign kept apart.
    assign mean_sel = (mode_reg == hlwr_pkg::MODE_MEAN);
    assign dvd      = mean_sel ? {lsum_reg, {FRAC_BITS{1'b0}}} : DVW'(lsum_reg);
    assign dvd_mag  = lsum_reg[LW-1] ? -dvd : dvd;
    assign dsr      = mean_sel ? (wsum_reg[WW-1] ? -wsum_reg : wsum_reg)
                               : DSW'(cnt_reg);

    // One restoring step per cycle: shift in a dividend bit, try a subtract.
    assign rem_sh = {rem_reg, quo_reg[DVW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};
    assign take   = !diff[DSW+1];

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            quo_reg  <= dvd_mag;
            rem_reg  <= '0;
            dsr_reg  <= dsr;
            neg_reg  <= lsum_reg[LW-1] ^ (mean_sel & wsum_reg[WW-1]);
            zero_reg <= (dsr == '0);
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[DVW-2:0], take};
            rem_reg <= take ? diff[DSW-1:0] : rem_sh[DSW-1:0];
        end
    end

    // Saturate the signed quotient to the result width.
    always_comb begin
        if (neg_reg) begin
            quo_ovf = (|quo_reg[DVW-1:LW]) || (quo_reg[LW-1] && (|quo_reg[LW-2:0]));
            quo_sat = quo_ovf ? hlwr_pkg::LOSS_MIN : -quo_reg[LW-1:0];
        end else begin
            quo_ovf = |quo_reg[DVW-1:LW-1];
            quo_sat = quo_ovf ? hlwr_pkg::LOSS_MAX : quo_reg[LW-1:0];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (cmd.advance && sts.emits) begin
            if (mode_reg == hlwr_pkg::MODE_SUM) begin
                m_result_value <= lsum_sat;
            end else begin
                m_result_value <= LW'(loss_reg);
            end
            m_is_last <= last_reg;
        end else if (cmd.fin_load) begin
            m_result_value <= zero_reg ? '0 : quo_sat;
            m_is_last      <= 1'b1;
        end
    end

endmodule

// ===== src/hinge_loss_weighted_reduce_core.sv =====
// Weighted hinge loss with reduction. Each input beat carries one element
// (Q8.8 logit, label bit, Q8.8 weight, last flag) and the block takes one
// beat per cycle while its output is not stalled and the divider is idle. In
// mode 0 every element gives a Q16.16 weighted loss; in modes 1 to 3 only the
// last element gives a beat, the saturated weighted sum or that sum divided
// by the weight sum or by the nonzero-weight count (zero divisor gives 0,
// division truncates toward zero). A result beat passes through the input
// stage register and then the output register. The last element of an array
// in modes 2 and 3 holds intake while the radix-2 restoring divider runs: one
// state loads it, then it produces one quotient bit per cycle over a dividend
// of 48 + FRAC_BITS bits, and a final state saturates its result.
// Accumulators clear after every last element.
module hinge_loss_weighted_reduce_core #(
    parameter int MAX_ELEMENTS = hlwr_pkg::MAX_ELEMENTS_DEF,
    parameter int FRAC_BITS    = hlwr_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [hlwr_pkg::MODE_W-1:0]        cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [hlwr_pkg::IN_W-1:0]   s_logit,
    input  logic                               s_label_bit,
    input  logic signed [hlwr_pkg::IN_W-1:0]   s_weight,
    input  logic                               s_last_element,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [hlwr_pkg::LOSS_W-1:0] m_result_value,
    output logic                               m_is_last
);

    hlwr_pkg::cmd_t cmd;
    hlwr_pkg::sts_t sts;

    // Sequencer for intake, division and the output register.
    hlwr_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Loss, accumulators, divider and result register.
    hlwr_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_logit        (s_logit),
        .s_label_bit    (s_label_bit),
        .s_weight       (s_weight),
        .s_last_element (s_last_element),
        .m_result_value (m_result_value),
        .m_is_last      (m_is_last),
        .cmd            (cmd),
        .sts            (sts)
    );

    // No intake while the divider runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_ready)
        else $error("input accepted during division");

    // A waiting result beat is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !(cmd.advance && sts.emits) && !cmd.fin_load)
        else $error("result beat overwritten while stalled");

    // Loading the divider is always followed by division steps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_load |=> cmd.div_step)
        else $error("divider loaded but not stepped");

endmodule

// ===== dv/tb_hinge_loss_weighted_reduce_core.sv =====
`timescale 1ns / 1ps

module tb_hinge_loss_weighted_reduce_core;

    localparam int IN_W   = hlwr_pkg::IN_W;
    localparam int LOSS_W = hlwr_pkg::LOSS_W;
    localparam int WSUM_W = hlwr_pkg::WSUM_W;
    localparam int MODE_W = hlwr_pkg::MODE_W;

    localparam int SETTLE_CYCLES = 80;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SKEW_PAIRS    = 12;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 60;

    typedef enum {MIXED, ZERO_WEIGHTS, MIRRORED} array_kind_t;

    typedef struct {
        logic [LOSS_W-1:0] value;
        logic              is_last;
    } loss_beat_t;

    // Tracks the accumulators and the mode of the block and holds the result
    // beats still owed by it, oldest first.
    class hinge_scoreboard;
        logic [MODE_W-1:0] mode       = hlwr_pkg::MODE_NONE;
        longint            loss_acc   = 0;
        longint            weight_acc = 0;
        int                nz_count   = 0;
        loss_beat_t        due_q[$];
        int                errors     = 0;

        static function longint saturate(longint v, int width);
            longint top;
            top = (longint'(1) <<< (width - 1)) - 1;
            if (v > top) return top;
            if (v < -top - 1) return -top - 1;
            return v;
        endfunction

        function void note_element(logic signed [IN_W-1:0] logit, logic label,
                                   logic signed [IN_W-1:0] weight, logic last);
            longint     unit;
            longint     hinge;
            longint     loss;
            longint     reduced;
            loss_beat_t beat;
            unit  = longint'(1) <<< hlwr_pkg::FRAC_BITS_DEF;
            hinge = label ? unit - longint'(logit) : unit + longint'(logit);
            if (hinge < 0) hinge = 0;
            loss = hinge * longint'(weight);

            // Accumulate in every mode, saturating at the register widths.
            loss_acc   = saturate(loss_acc + loss, LOSS_W);
            weight_acc = saturate(weight_acc + longint'(weight), WSUM_W);
            if (weight != 0 && nz_count < hlwr_pkg::MAX_ELEMENTS_DEF) nz_count++;

            // Per-element beat, or one reduced beat at the end of the array.
            if (mode == hlwr_pkg::MODE_NONE) begin
                beat.value   = loss[LOSS_W-1:0];
                beat.is_last = last;
                due_q.push_back(beat);
            end else if (last) begin
                reduced = 0;
                case (mode)
                    hlwr_pkg::MODE_SUM: begin
                        reduced = loss_acc;
                    end
                    hlwr_pkg::MODE_MEAN: begin
                        if (weight_acc != 0) reduced = (loss_acc * unit) / weight_acc;
                    end
                    hlwr_pkg::MODE_COUNT: begin
                        if (nz_count != 0) reduced = loss_acc / longint'(nz_count);
                    end
                    default: begin
                        reduced = 0;
                    end
                endcase
                reduced      = saturate(reduced, LOSS_W);
                beat.value   = reduced[LOSS_W-1:0];
                beat.is_last = 1'b1;
                due_q.push_back(beat);
            end

            if (last) begin
                loss_acc   = 0;
                weight_acc = 0;
                nz_count   = 0;
            end
        endfunction

        function void check_result(logic [LOSS_W-1:0] value, logic is_last);
            loss_beat_t beat;
            if (due_q.size() == 0) begin
                $error("result beat with none outstanding: result_value %0d, is_last %0d",
                       $signed(value), is_last);
                errors++;
            end else begin
                beat = due_q.pop_front();
                if (value !== beat.value) begin
                    $error("result_value: expected %0d, actual %0d",
                           $signed(beat.value), $signed(value));
                    errors++;
                end
                if (is_last !== beat.is_last) begin
                    $error("is_last: expected %0d, actual %0d", beat.is_last, is_last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn        = 1'b0;
    logic                          cfg_wr_en      = 1'b0;
    logic [MODE_W-1:0]             cfg_wr_data    = hlwr_pkg::MODE_NONE;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic signed [IN_W-1:0]        s_logit        = '0;
    logic                          s_label_bit    = 1'b0;
    logic signed [IN_W-1:0]        s_weight       = '0;
    logic                          s_last_element = 1'b0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic signed [LOSS_W-1:0]      m_result_value;
    logic                          m_is_last;

    int unsigned     sender_idle_pct    = 0;
    int unsigned     receiver_stall_pct = 0;
    int              cycle_count        = 0;
    hinge_scoreboard sb                 = new();

    hinge_loss_weighted_reduce_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_logit        (s_logit),
        .s_label_bit    (s_label_bit),
        .s_weight       (s_weight),
        .s_last_element (s_last_element),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_is_last      (m_is_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: check every accepted beat and stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_result_value, m_is_last);
        end
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Runaway guard.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic signed [IN_W-1:0] rand_logit();
        logic [31:0] bits;
        int          knee;
        bits = $urandom;
        case ($urandom_range(7))
            0: begin
                return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            end
            1: begin
                // Close to where the hinge reaches zero for either label.
                knee = (int'($urandom_range(1)) * 2 - 1) * (1 << hlwr_pkg::FRAC_BITS_DEF)
                       + int'($urandom_range(8)) - 4;
                return knee[IN_W-1:0];
            end
            default: begin
                return bits[IN_W-1:0];
            end
        endcase
    endfunction

    function automatic logic signed [IN_W-1:0] rand_weight();
        logic [31:0] bits;
        int          tiny;
        bits = $urandom;
        tiny = int'($urandom_range(6)) - 3;
        case ($urandom_range(7))
            0: begin
                return '0;
            end
            1: begin
                return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            end
            2: begin
                return tiny[IN_W-1:0];
            end
            default: begin
                return bits[IN_W-1:0];
            end
        endcase
    endfunction

    // Present one element and hold it until the block takes the beat.
    task automatic send_element(input logic signed [IN_W-1:0] logit, input logic label,
                                input logic signed [IN_W-1:0] weight, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_logit        <= logit;
        s_label_bit    <= label;
        s_weight       <= weight;
        s_last_element <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_element(logit, label, weight, last);
    endtask

    // Wait until every owed beat has arrived and the divider has gone quiet.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.mode      = mode;
    endtask

    task automatic send_array(input int count, input array_kind_t kind, input logic close);
        logic signed [IN_W-1:0] weight;
        weight = '0;
        for (int i = 0; i < count; i++) begin
            case (kind)
                ZERO_WEIGHTS: begin
                    weight = '0;
                end
                MIRRORED: begin
                    weight = (i % 2 == 0) ? rand_weight() : -weight;
                end
                default: begin
                    weight = rand_weight();
                end
            endcase
            send_element(rand_logit(), 1'($urandom_range(1)), weight, close && i == count - 1);
        end
    endtask

    // Large loss against a weight sum of one unit step, so the mean is far
    // above any single weighted loss and keeps every quotient bit busy.
    task automatic send_skewed_array(input logic signed [IN_W-1:0] closing_weight);
        for (int i = 0; i < SKEW_PAIRS; i++) begin
            send_element(16'sh8000, 1'b1, 16'sh7FFF, 1'b0);
            send_element(16'sh7FFF, 1'b1, -16'sd32767, 1'b0);
        end
        send_element(16'sh7FFF, 1'b1, closing_weight, 1'b1);
    endtask

    initial begin
        int          phase_items;
        int          count;
        array_kind_t kind;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Per-element losses at the field extremes and around the hinge knee.
        write_mode(hlwr_pkg::MODE_NONE);
        send_element(16'sh8000, 1'b1, 16'sh7FFF, 1'b0);
        send_element(16'sh8000, 1'b1, 16'sh8000, 1'b0);
        send_element(16'sh7FFF, 1'b0, 16'sh8000, 1'b0);
        send_element(16'sh7FFF, 1'b1, 16'sh7FFF, 1'b0);
        send_element(16'sd256, 1'b1, 16'sd100, 1'b0);
        send_element(16'sd255, 1'b1, -16'sd1, 1'b0);
        send_element(-16'sd256, 1'b0, -16'sd77, 1'b0);
        send_element(16'sd0, 1'b0, 16'sd0, 1'b1);

        write_mode(hlwr_pkg::MODE_SUM);
        send_element(16'sd100, 1'b0, 16'sd512, 1'b0);
        send_element(-16'sd300, 1'b1, -16'sd3, 1'b0);
        send_element(16'sd5, 1'b1, 16'sh7FFF, 1'b1);

        // Zero weight sum gives zero, then an ordinary truncating mean.
        write_mode(hlwr_pkg::MODE_MEAN);
        send_element(16'sd10, 1'b1, 16'sd0, 1'b0);
        send_element(16'sd20, 1'b0, 16'sd0, 1'b1);
        send_element(16'sd50, 1'b0, 16'sd300, 1'b0);
        send_element(-16'sd700, 1'b1, -16'sd7, 1'b0);
        send_element(16'sd3, 1'b1, 16'sd11, 1'b1);

        // No nonzero weight gives zero, then a negative sum over the count.
        write_mode(hlwr_pkg::MODE_COUNT);
        send_element(16'sd1, 1'b1, 16'sd0, 1'b1);
        send_element(16'sd0, 1'b0, 16'sd0, 1'b0);
        send_element(-16'sd40, 1'b1, 16'sd7, 1'b0);
        send_element(16'sd600, 1'b0, -16'sd3, 1'b1);

        // The mode changes twice inside one array; the accumulators carry on.
        send_element(16'sd12, 1'b1, 16'sd9, 1'b0);
        send_element(-16'sd9, 1'b0, -16'sd2, 1'b0);
        write_mode(hlwr_pkg::MODE_NONE);
        send_element(16'sd77, 1'b1, 16'sd5, 1'b0);
        write_mode(hlwr_pkg::MODE_MEAN);
        send_element(-16'sd1, 1'b1, 16'sd4, 1'b1);

        // Large quotients of either sign.
        send_skewed_array(16'sd1);
        send_skewed_array(-16'sd1);

        // Random arrays over every pairing of mode and pacing.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_mode(MODE_W'((phase + phase / 4) % 4));
            case (phase % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 77;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 77;
                end
                default: begin
                    sender_idle_pct    = 31;
                    receiver_stall_pct = 31;
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                count = ($urandom_range(9) == 0) ? int'($urandom_range(40, 9))
                                                 : int'($urandom_range(8, 1));
                case ($urandom_range(9))
                    0: begin
                        kind = ZERO_WEIGHTS;
                    end
                    1, 2: begin
                        kind = MIRRORED;
                    end
                    default: begin
                        kind = MIXED;
                    end
                endcase
                send_array(count, kind, 1'b1);
                phase_items += count;
            end
            // Leave an array open across the next mode change now and then.
            if ($urandom_range(1) == 1) begin
                send_array(int'($urandom_range(3, 1)), MIXED, 1'b0);
            end
        end

        drain_results();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/hlwr_pkg.sv
src/hlwr_ctrl.sv
src/hlwr_dp.sv
src/hinge_loss_weighted_reduce_core.sv
dv/tb_hinge_loss_weighted_reduce_core.sv
